// File: rtl/htd_pkg.sv
// Shared types, codes and constants for the Huffman tree decoder with usage histogram.
// Used by every module of the block; depends on nothing else.
package htd_pkg;

   // Fixed widths of the command and result fields.
   localparam int OP_W    = 3;
   localparam int BOOK_W  = 3;
   localparam int IDX_W   = 9;
   localparam int DATA_W  = 9;
   localparam int WIN_W   = 32;
   localparam int AVAIL_W = 6;
   localparam int DVAL_W  = 8;
   localparam int COUNT_W = 32;

   // Defaults of the top level parameters.
   localparam int NUM_BOOKS_DEF   = 8;
   localparam int TREE_WORDS_DEF  = 512;
   localparam int MAX_VALUES_DEF  = 256;
   localparam int WINDOW_BITS_DEF = 32;

   // The book field can only name this many books.
   localparam int MAX_BOOK_SLOTS = 2 ** BOOK_W;

   // Depth of the command queue between the front and the back.
   localparam int CMDQ_DEPTH = 2;

   // Operation codes as they arrive on the request port.
   typedef enum logic [OP_W-1:0] {
      OP_LOAD_TREE = 3'd0,
      OP_LOAD_MAP  = 3'd1,
      OP_SET_SIZE  = 3'd2,
      OP_DECODE    = 3'd3,
      OP_READ_CNT  = 3'd4,
      OP_CLEAR_CNT = 3'd5
   } op_type;

   // Classified command as queued for the back end.
   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_TREE,
      CMD_MAP,
      CMD_SIZE,
      CMD_DECODE,
      CMD_READ,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [BOOK_W-1:0]   book;
      logic [IDX_W-1:0]    index;
      logic [DATA_W-1:0]   data;
      logic [WIN_W-1:0]    window;
      logic [AVAIL_W-1:0]  lim;
   } cmd_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_WALK,
      BK_MAP,
      BK_INC,
      BK_READ,
      BK_CLEAR
   } bk_state_type;

endpackage

// File: rtl/htd_front.sv
// Front end: takes a request beat and turns it into a classified, range-checked command.
// Depends on htd_pkg.
module htd_front #(
   parameter int NUM_BOOKS   = htd_pkg::NUM_BOOKS_DEF,
   parameter int TREE_WORDS  = htd_pkg::TREE_WORDS_DEF,
   parameter int MAX_VALUES  = htd_pkg::MAX_VALUES_DEF,
   parameter int WINDOW_BITS = htd_pkg::WINDOW_BITS_DEF
) (
   input  logic                         start,
   input  logic                         busy,
   input  logic [htd_pkg::OP_W-1:0]     req_operation,
   input  logic [htd_pkg::BOOK_W-1:0]   req_book,
   input  logic [htd_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [htd_pkg::DATA_W-1:0]   req_load_data,
   input  logic [htd_pkg::WIN_W-1:0]    req_bit_window,
   input  logic [htd_pkg::AVAIL_W-1:0]  req_bits_available,
   output logic                         push,
   output htd_pkg::cmd_type             cmd
);

   logic book_ok;
   logic tree_idx_ok;
   logic val_idx_ok;

   assign push        = start & ~busy;
   assign book_ok     = 32'(req_book) < 32'(NUM_BOOKS);
   assign tree_idx_ok = 32'(req_entry_index) < 32'(TREE_WORDS);
   assign val_idx_ok  = 32'(req_entry_index) < 32'(MAX_VALUES);

   always_comb begin
      cmd.book   = req_book;
      cmd.index  = req_entry_index;
      cmd.window = req_bit_window;
      cmd.data   = req_load_data;
      cmd.lim    = (32'(req_bits_available) < 32'(WINDOW_BITS)) ?
                   req_bits_available : htd_pkg::AVAIL_W'(WINDOW_BITS);
      cmd.kind   = htd_pkg::CMD_NOP;
      if (book_ok) begin
         unique case (htd_pkg::op_type'(req_operation))
            htd_pkg::OP_LOAD_TREE: begin
               if (tree_idx_ok) cmd.kind = htd_pkg::CMD_TREE;
            end
            htd_pkg::OP_LOAD_MAP: begin
               if (val_idx_ok) cmd.kind = htd_pkg::CMD_MAP;
            end
            htd_pkg::OP_SET_SIZE: begin
               // Book sizes saturate at the value map depth.
               cmd.kind = htd_pkg::CMD_SIZE;
               cmd.data = (32'(req_load_data) > 32'(MAX_VALUES)) ?
                          htd_pkg::DATA_W'(MAX_VALUES) : req_load_data;
            end
            htd_pkg::OP_DECODE:    cmd.kind = htd_pkg::CMD_DECODE;
            htd_pkg::OP_READ_CNT: begin
               if (val_idx_ok) cmd.kind = htd_pkg::CMD_READ;
            end
            htd_pkg::OP_CLEAR_CNT: cmd.kind = htd_pkg::CMD_CLEAR;
            default:               cmd.kind = htd_pkg::CMD_NOP;
         endcase
      end
   end

endmodule

// File: rtl/htd_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on htd_pkg for the command type and depth.
module htd_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  htd_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output htd_pkg::cmd_type  head_cmd
);

   localparam int QPW = (htd_pkg::CMDQ_DEPTH > 1) ? $clog2(htd_pkg::CMDQ_DEPTH) : 1;

   htd_pkg::cmd_type  slot_ff [htd_pkg::CMDQ_DEPTH];
   logic [QPW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPW:0]      fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full      = fill_ff == (QPW+1)'(htd_pkg::CMDQ_DEPTH);
   assign not_empty = fill_ff != '0;
   assign head_cmd  = slot_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(htd_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(htd_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/htd_back.sv
// Back end: owns the tree, value map, book size and counter stores and executes commands.
// Depends on htd_pkg; fed from htd_cmd_queue.
module htd_back #(
   parameter int NUM_BOOKS   = htd_pkg::NUM_BOOKS_DEF,
   parameter int TREE_WORDS  = htd_pkg::TREE_WORDS_DEF,
   parameter int MAX_VALUES  = htd_pkg::MAX_VALUES_DEF,
   parameter int WINDOW_BITS = htd_pkg::WINDOW_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  htd_pkg::cmd_type              cmd,
   output logic                          pop,
   output logic                          init_busy,
   output logic                          rsp_valid,
   output logic                          rsp_status,
   output logic [htd_pkg::DVAL_W-1:0]    rsp_decoded_value,
   output logic [htd_pkg::AVAIL_W-1:0]   rsp_bits_used,
   output logic [htd_pkg::COUNT_W-1:0]   rsp_count_value
);

   localparam int BOOK_SLOTS = (NUM_BOOKS < htd_pkg::MAX_BOOK_SLOTS) ?
                               NUM_BOOKS : htd_pkg::MAX_BOOK_SLOTS;
   localparam int BSW        = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;
   localparam int TREE_DEPTH = BOOK_SLOTS * TREE_WORDS;
   localparam int VAL_DEPTH  = BOOK_SLOTS * MAX_VALUES;
   localparam int TAW        = $clog2(TREE_DEPTH);
   localparam int CAW        = $clog2(VAL_DEPTH);
   // Pointer and range bounds grow by at most one span per consumed bit.
   localparam int WW         = $clog2((WINDOW_BITS + 1) * (2 ** htd_pkg::DATA_W));

   localparam logic [TAW-1:0] TREE_STRIDE = TAW'(TREE_WORDS);
   localparam logic [CAW-1:0] VAL_STRIDE  = CAW'(MAX_VALUES);

   // Stores
   logic [htd_pkg::DATA_W-1:0]   tree_mem [TREE_DEPTH];
   logic [htd_pkg::DVAL_W-1:0]   map_mem  [VAL_DEPTH];
   logic [htd_pkg::COUNT_W-1:0]  cnt_mem  [VAL_DEPTH];
   logic [htd_pkg::DATA_W-1:0]   size_ff  [BOOK_SLOTS];

   logic [htd_pkg::DATA_W-1:0]   tree_q;
   logic [htd_pkg::DVAL_W-1:0]   map_q;
   logic [htd_pkg::COUNT_W-1:0]  cnt_q;

   logic                         tree_we;
   logic [TAW-1:0]               tree_waddr, tree_raddr;
   logic                         map_we;
   logic [CAW-1:0]               map_waddr, map_raddr;
   logic                         cnt_we;
   logic [CAW-1:0]               cnt_waddr, cnt_raddr;
   logic [htd_pkg::COUNT_W-1:0]  cnt_wdata;
   logic                         size_we;

   // Sequencer state and walk registers
   htd_pkg::bk_state_type        state_ff, state_in;
   logic [WW-1:0]                p_ff, p_in;
   logic [WW-1:0]                l_ff, l_in;
   logic [WW-1:0]                r_ff, r_in;
   logic [htd_pkg::AVAIL_W-1:0]  n_ff, n_in;
   logic [htd_pkg::AVAIL_W-1:0]  lim_ff, lim_in;
   logic [htd_pkg::WIN_W-1:0]    win_ff, win_in;
   logic [TAW-1:0]               tbase_ff, tbase_in;
   logic [CAW-1:0]               cbase_ff, cbase_in;
   logic [CAW-1:0]               cnt_addr_ff, cnt_addr_in;
   logic [CAW-1:0]               sweep_ff, sweep_in;
   logic [htd_pkg::DVAL_W-1:0]   sym_ff, sym_in;
   logic                         oor_ff, oor_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         status_ff, status_in;
   logic [htd_pkg::DVAL_W-1:0]   dval_ff, dval_in;
   logic [htd_pkg::AVAIL_W-1:0]  used_ff, used_in;
   logic [htd_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic [TAW-1:0]               tbase_calc;
   logic [CAW-1:0]               cbase_calc;
   logic [WW-1:0]                node;

   assign init_busy         = state_ff == htd_pkg::BK_INIT;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_decoded_value = dval_ff;
   assign rsp_bits_used     = used_ff;
   assign rsp_count_value   = count_ff;

   assign tbase_calc = TAW'(cmd.book) * TREE_STRIDE;
   assign cbase_calc = CAW'(cmd.book) * VAL_STRIDE;
   assign node       = oor_ff ? '0 : WW'(tree_q);

   // Tree reads follow the next pointer so one bit is consumed per cycle.
   assign tree_raddr = tbase_in + TAW'(p_in);
   assign oor_in     = 32'(p_in) >= 32'(TREE_WORDS);

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      n_in         = n_ff;
      lim_in       = lim_ff;
      win_in       = win_ff;
      tbase_in     = tbase_ff;
      cbase_in     = cbase_ff;
      cnt_addr_in  = cnt_addr_ff;
      sweep_in     = sweep_ff;
      sym_in       = sym_ff;
      pop          = 1'b0;
      tree_we      = 1'b0;
      tree_waddr   = tbase_calc + TAW'(cmd.index);
      map_we       = 1'b0;
      map_waddr    = cbase_calc + CAW'(cmd.index);
      map_raddr    = cbase_ff + CAW'(l_ff);
      size_we      = 1'b0;
      cnt_we       = 1'b0;
      cnt_waddr    = cnt_addr_ff;
      cnt_wdata    = '0;
      cnt_raddr    = cbase_calc + CAW'(cmd.index);
      rsp_valid_in = 1'b0;
      status_in    = 1'b0;
      dval_in      = '0;
      used_in      = '0;
      count_in     = '0;

      unique case (state_ff)
         htd_pkg::BK_INIT: begin
            cnt_we    = 1'b1;
            cnt_waddr = sweep_ff;
            if (sweep_ff == CAW'(VAL_DEPTH - 1)) begin
               sweep_in = '0;
               state_in = htd_pkg::BK_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         htd_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               pop = 1'b1;
               unique case (cmd.kind)
                  htd_pkg::CMD_TREE: begin
                     tree_we      = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  htd_pkg::CMD_MAP: begin
                     map_we       = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  htd_pkg::CMD_SIZE: begin
                     size_we      = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  htd_pkg::CMD_DECODE: begin
                     p_in     = '0;
                     l_in     = '0;
                     r_in     = WW'(size_ff[BSW'(cmd.book)]);
                     n_in     = '0;
                     lim_in   = cmd.lim;
                     win_in   = cmd.window;
                     tbase_in = tbase_calc;
                     cbase_in = cbase_calc;
                     state_in = htd_pkg::BK_WALK;
                  end
                  htd_pkg::CMD_READ: begin
                     state_in = htd_pkg::BK_READ;
                  end
                  htd_pkg::CMD_CLEAR: begin
                     cbase_in = cbase_calc;
                     sweep_in = '0;
                     state_in = htd_pkg::BK_CLEAR;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         htd_pkg::BK_WALK: begin
            if ((l_ff + WW'(1)) == r_ff) begin
               if (32'(l_ff) >= 32'(MAX_VALUES)) begin
                  rsp_valid_in = 1'b1;
                  status_in    = 1'b1;
                  used_in      = n_ff;
                  state_in     = htd_pkg::BK_IDLE;
               end else begin
                  state_in = htd_pkg::BK_MAP;
               end
            end else if (n_ff >= lim_ff) begin
               rsp_valid_in = 1'b1;
               status_in    = 1'b1;
               used_in      = n_ff;
               state_in     = htd_pkg::BK_IDLE;
            end else begin
               n_in   = n_ff + 1'b1;
               win_in = win_ff >> 1;
               if (win_ff[0]) begin
                  l_in = l_ff + node;
                  p_in = p_ff + node;
               end else begin
                  r_in = l_ff + node;
                  p_in = p_ff + WW'(1);
               end
            end
         end

         htd_pkg::BK_MAP: begin
            sym_in      = map_q;
            cnt_raddr   = cbase_ff + CAW'(map_q);
            cnt_addr_in = cbase_ff + CAW'(map_q);
            if (32'(map_q) < 32'(MAX_VALUES)) begin
               state_in = htd_pkg::BK_INC;
            end else begin
               rsp_valid_in = 1'b1;
               dval_in      = map_q;
               used_in      = n_ff;
               state_in     = htd_pkg::BK_IDLE;
            end
         end

         htd_pkg::BK_INC: begin
            cnt_we       = 1'b1;
            cnt_waddr    = cnt_addr_ff;
            cnt_wdata    = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
            rsp_valid_in = 1'b1;
            dval_in      = sym_ff;
            used_in      = n_ff;
            state_in     = htd_pkg::BK_IDLE;
         end

         htd_pkg::BK_READ: begin
            rsp_valid_in = 1'b1;
            count_in     = cnt_q;
            state_in     = htd_pkg::BK_IDLE;
         end

         htd_pkg::BK_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = cbase_ff + sweep_ff;
            if (sweep_ff == CAW'(MAX_VALUES - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = htd_pkg::BK_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         default: begin
            state_in = htd_pkg::BK_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= htd_pkg::BK_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < BOOK_SLOTS; i++) begin
            size_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (size_we) begin
            size_ff[BSW'(cmd.book)] <= cmd.data;
         end
      end
   end

   // Walk and result payload
   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      n_ff        <= n_in;
      lim_ff      <= lim_in;
      win_ff      <= win_in;
      tbase_ff    <= tbase_in;
      cbase_ff    <= cbase_in;
      cnt_addr_ff <= cnt_addr_in;
      sym_ff      <= sym_in;
      oor_ff      <= oor_in;
      status_ff   <= status_in;
      dval_ff     <= dval_in;
      used_ff     <= used_in;
      count_ff    <= count_in;
   end

   // Tree store
   always_ff @(posedge clock) begin
      if (tree_we) begin
         tree_mem[tree_waddr] <= cmd.data;
      end
      tree_q <= tree_mem[tree_raddr];
   end

   // Value map store
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= cmd.data[htd_pkg::DVAL_W-1:0];
      end
      map_q <= map_mem[map_raddr];
   end

   // Usage counter store
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_q <= cnt_mem[cnt_raddr];
   end

endmodule

// File: rtl/huffman_tree_decode_with_histogram_core.sv
// Top level of the Huffman tree decoder with per-value usage histogram.
// Instantiates htd_front, htd_cmd_queue and htd_back; depends on htd_pkg.
//
// A command beat is taken when start is high and busy is low, and every command
// produces exactly one result beat: rsp_valid is high for one cycle with the result
// fields, and the receiver must take it then, as the block cannot be held off. A
// front end checks and classifies each command and places it in a two-entry queue;
// the back end executes queued commands strictly in order, so commands may be issued
// back to back until the queue fills. Tree, map and book size loads, reads of an
// out-of-range entry and commands for an absent book are answered from the idle
// state. A count read passes through the read state. A decode ends in the walk
// state when it ends without a symbol, and passes on through the map and increment
// states when it counts one; the walk consumes one window bit per cycle, because
// each step reads the next tree word from the single tree store port. Clearing a
// book's counters sweeps the counter store one entry per cycle.
// After reset the whole counter store is swept to zero first, all of its
// min(NUM_BOOKS, 8) * MAX_VALUES entries (2048 with the defaults), and busy stays
// high throughout. Tree words and value map entries hold nothing until loaded.
module huffman_tree_decode_with_histogram_core #(
   parameter int NUM_BOOKS   = htd_pkg::NUM_BOOKS_DEF,
   parameter int TREE_WORDS  = htd_pkg::TREE_WORDS_DEF,
   parameter int MAX_VALUES  = htd_pkg::MAX_VALUES_DEF,
   parameter int WINDOW_BITS = htd_pkg::WINDOW_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [htd_pkg::OP_W-1:0]      req_operation,
   input  logic [htd_pkg::BOOK_W-1:0]    req_book,
   input  logic [htd_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [htd_pkg::DATA_W-1:0]    req_load_data,
   input  logic [htd_pkg::WIN_W-1:0]     req_bit_window,
   input  logic [htd_pkg::AVAIL_W-1:0]   req_bits_available,
   output logic                          rsp_valid,
   output logic                          rsp_status,
   output logic [htd_pkg::DVAL_W-1:0]    rsp_decoded_value,
   output logic [htd_pkg::AVAIL_W-1:0]   rsp_bits_used,
   output logic [htd_pkg::COUNT_W-1:0]   rsp_count_value
);

   logic              push;
   logic              q_full;
   logic              q_not_empty;
   logic              q_pop;
   logic              init_busy;
   htd_pkg::cmd_type  front_cmd;
   htd_pkg::cmd_type  head_cmd;

   // The block refuses commands while the queue is full or the counters are
   // still being swept after reset.
   assign busy = q_full | init_busy;

   htd_front #(
      .NUM_BOOKS   (NUM_BOOKS),
      .TREE_WORDS  (TREE_WORDS),
      .MAX_VALUES  (MAX_VALUES),
      .WINDOW_BITS (WINDOW_BITS)
   ) u_front (
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_book           (req_book),
      .req_entry_index    (req_entry_index),
      .req_load_data      (req_load_data),
      .req_bit_window     (req_bit_window),
      .req_bits_available (req_bits_available),
      .push               (push),
      .cmd                (front_cmd)
   );

   htd_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   htd_back #(
      .NUM_BOOKS   (NUM_BOOKS),
      .TREE_WORDS  (TREE_WORDS),
      .MAX_VALUES  (MAX_VALUES),
      .WINDOW_BITS (WINDOW_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (q_not_empty),
      .cmd               (head_cmd),
      .pop               (q_pop),
      .init_busy         (init_busy),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_decoded_value (rsp_decoded_value),
      .rsp_bits_used     (rsp_bits_used),
      .rsp_count_value   (rsp_count_value)
   );

endmodule
